// File: rtl/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types and constants for the motor setpoint conditioner.
// ----------------------------------------------------------------------------
package msc_pkg;

  // Depth of the median window.
  localparam int WINDOW_SIZE = 5;
  localparam int SLOT_W      = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);

  // Full-scale values of the potentiometer, the PWM range and the percent weight.
  localparam int POT_FULL = 1023;
  localparam int PWM_FULL = 255;
  localparam int PCT_FULL = 100;

  // Division by one hundred is done as a multiplication by 5243 / 2^19.
  // This is exact for every dividend below 25600.
  localparam int AVG_RECIP = 5243;
  localparam int AVG_SHIFT = 19;

  localparam int ADDR_W = 5;

  // Configuration register indexes (byte address is four times the index).
  typedef enum logic [2:0] {
    REG_PWM_MIN    = 3'd0,
    REG_PWM_MAX    = 3'd1,
    REG_AVG_WEIGHT = 3'd2,
    REG_SLEW_STEP  = 3'd3,
    REG_ALERT_SET  = 3'd4,
    REG_ALERT_CLR  = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SELECT,
    S_MEDIAN,
    S_AVG_SUM,
    S_AVG_DIV,
    S_RAMP
  } ctrl_state_e;

  typedef struct packed {
    logic [7:0] pwm_min;
    logic [7:0] pwm_max;
    logic [6:0] avg_weight_pct;
    logic [7:0] slew_step;
    logic [7:0] alert_set_lvl;
    logic [7:0] alert_clr_lvl;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic select;
    logic med_step;
    logic avg_sum;
    logic avg_div;
    logic ramp_commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic med_found;
  } stat_t;

  // Result word, last field in the lowest bits.
  typedef struct packed {
    logic               pwm_at_max;
    logic               alert;
    logic [7:0]         ramped_pwm;
    logic [7:0]         average_value;
    logic [7:0]         median_value;
    logic [7:0]         clamped_value;
    logic signed [10:0] selected_value;
    logic [7:0]         pot_scaled;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int OUT_W    = ((RESULT_W + 7) / 8) * 8;
  localparam int IN_W     = 24;

endpackage

// File: rtl/msc_ctrl.sv
// ----------------------------------------------------------------------------
// msc_ctrl
// Sequencer for one setpoint word: select, median search, average, ramp.
// ----------------------------------------------------------------------------
module msc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output msc_pkg::cmd_t cmd_o,
  input  msc_pkg::stat_t stat_i
);
  import msc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_SELECT;
        end
      end
      S_SELECT: begin
        cmd_o.select = 1'b1;
        state_d      = S_MEDIAN;
      end
      S_MEDIAN: begin
        cmd_o.med_step = 1'b1;
        if (stat_i.med_found) begin
          state_d = S_AVG_SUM;
        end
      end
      S_AVG_SUM: begin
        cmd_o.avg_sum = 1'b1;
        state_d       = S_AVG_DIV;
      end
      S_AVG_DIV: begin
        cmd_o.avg_div = 1'b1;
        state_d       = S_RAMP;
      end
      S_RAMP: begin
        // The ramp state and the output register update together, so wait
        // until the output register can take the word.
        if (out_free) begin
          cmd_o.ramp_commit = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.ramp_commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_load_starts_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_in |=> state_q == S_SELECT)
    else $error("accepted word did not start the select step");

  a_commit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ramp_commit |-> (!out_valid_q || out_ready_i))
    else $error("result committed over an untaken word");

  a_valid_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.ramp_commit))
    else $error("output valid rose without a commit");

endmodule

// File: rtl/msc_datapath.sv
// ----------------------------------------------------------------------------
// msc_datapath
// Scaling, clamp, median window, moving average and slew limiter.
// ----------------------------------------------------------------------------
module msc_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  msc_pkg::cfg_t    cfg_i,
  input  msc_pkg::cmd_t    cmd_i,
  output msc_pkg::stat_t   stat_o,
  input  logic             mode_auto_i,
  input  logic [9:0]       pot_sample_i,
  input  logic signed [10:0] manual_target_i,
  output msc_pkg::result_t result_o
);
  import msc_pkg::*;

  function automatic logic [7:0] clamp_pwm(logic signed [10:0] v, logic [7:0] lo,
                                           logic [7:0] hi);
    logic signed [10:0] lo_s;
    logic signed [10:0] hi_s;
    lo_s = signed'({3'b000, lo});
    hi_s = signed'({3'b000, hi});
    if (v < lo_s) return lo;
    if (v > hi_s) return hi;
    return v[7:0];
  endfunction

  // Input word.
  logic               mode_q;
  logic [9:0]         pot_q;
  logic signed [10:0] manual_q;

  // Window and its bookkeeping.
  logic [7:0]        window_q [WINDOW_SIZE];
  logic [SLOT_W-1:0] slot_q;
  logic [CNT_W-1:0]  filled_q;
  logic [SLOT_W-1:0] med_idx_q;

  // Per-word intermediate values.
  logic [7:0]         pot_scaled_q;
  logic signed [10:0] selected_q;
  logic [7:0]         clamped_q;
  logic [7:0]         median_q;
  logic [14:0]        sum_q;

  // Persistent state.
  logic [7:0] avg_q;
  logic       primed_q;
  logic [7:0] ramp_q;
  logic       alert_q;
  result_t    result_q;

  // ---- scaling: x*255/1023 via a shift estimate and one correction ----
  logic [17:0]        pot_x255;
  logic [7:0]         q_est;
  logic [17:0]        q_rem;
  logic [7:0]         pot_scaled;
  logic signed [10:0] selected;
  logic [7:0]         clamped;

  assign pot_x255   = {pot_q, 8'b0} - {8'b0, pot_q};
  assign q_est      = pot_x255[17:10];
  assign q_rem      = pot_x255 - {q_est, 10'b0} + {10'b0, q_est};
  assign pot_scaled = (q_rem >= 18'(POT_FULL)) ? q_est + 8'd1 : q_est;
  assign selected   = mode_q ? signed'({3'b000, pot_scaled}) : manual_q;
  assign clamped    = clamp_pwm(selected, cfg_i.pwm_min, cfg_i.pwm_max);

  // ---- median: rank test of one candidate per cycle ----
  logic [7:0]             cand;
  logic [WINDOW_SIZE-1:0] lt_vec;
  logic [WINDOW_SIZE-1:0] le_vec;
  logic [CNT_W-1:0]       cnt_lt;
  logic [CNT_W-1:0]       cnt_le;
  logic [CNT_W-1:0]       mid_rank;

  assign cand = window_q[med_idx_q];

  always_comb begin
    for (int j = 0; j < WINDOW_SIZE; j++) begin
      lt_vec[j] = (CNT_W'(j) < filled_q) && (window_q[j] <  cand);
      le_vec[j] = (CNT_W'(j) < filled_q) && (window_q[j] <= cand);
    end
  end

  assign cnt_lt           = CNT_W'($countones(lt_vec));
  assign cnt_le           = CNT_W'($countones(le_vec));
  assign mid_rank         = filled_q >> 1;
  assign stat_o.med_found = (cnt_lt <= mid_rank) && (mid_rank < cnt_le);

  // ---- moving average ----
  logic [6:0]  weight;
  logic [6:0]  weight_inv;
  logic [27:0] avg_prod;

  assign weight     = (cfg_i.avg_weight_pct > 7'(PCT_FULL)) ? 7'(PCT_FULL)
                                                            : cfg_i.avg_weight_pct;
  assign weight_inv = 7'(PCT_FULL) - weight;
  assign avg_prod   = {13'b0, sum_q} * 28'(AVG_RECIP);

  // ---- slew limiter, re-clamp and flags ----
  logic signed [9:0]  avg_s;
  logic signed [9:0]  lvl_up;
  logic signed [9:0]  lvl_dn;
  logic signed [9:0]  lvl_next;
  logic [7:0]         ramped;
  logic               alert;
  logic               at_max;

  assign avg_s  = signed'({2'b00, avg_q});
  assign lvl_up = signed'({2'b00, ramp_q}) + signed'({2'b00, cfg_i.slew_step});
  assign lvl_dn = signed'({2'b00, ramp_q}) - signed'({2'b00, cfg_i.slew_step});

  always_comb begin
    if (avg_s > lvl_up) begin
      lvl_next = lvl_up;
    end else if (avg_s < lvl_dn) begin
      lvl_next = lvl_dn;
    end else begin
      lvl_next = avg_s;
    end
  end

  assign ramped = clamp_pwm({lvl_next[9], lvl_next}, cfg_i.pwm_min, cfg_i.pwm_max);
  assign alert  = alert_q ? (ramped >= cfg_i.alert_clr_lvl) : (ramped > cfg_i.alert_set_lvl);
  assign at_max = (ramped >= cfg_i.pwm_max);

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q   <= mode_auto_i;
      pot_q    <= pot_sample_i;
      manual_q <= manual_target_i;
    end
    if (cmd_i.select) begin
      window_q[slot_q] <= clamped;
      pot_scaled_q     <= mode_q ? pot_scaled : 8'd0;
      selected_q       <= selected;
      clamped_q        <= clamped;
    end
    if (cmd_i.med_step && stat_o.med_found) begin
      median_q <= cand;
    end
    if (cmd_i.avg_sum) begin
      sum_q <= ({8'b0, weight} * {7'b0, median_q}) + ({8'b0, weight_inv} * {7'b0, avg_q});
    end
    if (cmd_i.ramp_commit) begin
      result_q.pot_scaled     <= pot_scaled_q;
      result_q.selected_value <= selected_q;
      result_q.clamped_value  <= clamped_q;
      result_q.median_value   <= median_q;
      result_q.average_value  <= avg_q;
      result_q.ramped_pwm     <= ramped;
      result_q.alert          <= alert;
      result_q.pwm_at_max     <= at_max;
    end
  end

  // Control and persistent state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      filled_q  <= '0;
      med_idx_q <= '0;
      avg_q     <= '0;
      primed_q  <= 1'b0;
      ramp_q    <= '0;
      alert_q   <= 1'b0;
    end else begin
      if (cmd_i.select) begin
        slot_q    <= (slot_q == SLOT_W'(WINDOW_SIZE - 1)) ? '0 : slot_q + 1'b1;
        med_idx_q <= '0;
        if (filled_q < CNT_W'(WINDOW_SIZE)) begin
          filled_q <= filled_q + 1'b1;
        end
      end
      if (cmd_i.med_step && !stat_o.med_found) begin
        med_idx_q <= med_idx_q + 1'b1;
      end
      if (cmd_i.avg_div) begin
        // The first word loads the average with its clamped value.
        avg_q    <= primed_q ? avg_prod[AVG_SHIFT+7:AVG_SHIFT] : clamped_q;
        primed_q <= 1'b1;
      end
      if (cmd_i.ramp_commit) begin
        ramp_q  <= ramped;
        alert_q <= alert;
      end
    end
  end

  assign result_o = result_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= CNT_W'(WINDOW_SIZE) && slot_q < SLOT_W'(WINDOW_SIZE))
    else $error("window bookkeeping out of range");

  a_search_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.med_step |-> CNT_W'(med_idx_q) < filled_q)
    else $error("median search ran past the filled entries");

  a_ramp_in_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.ramp_commit && cfg_i.pwm_min <= cfg_i.pwm_max)
      |=> ramp_q >= cfg_i.pwm_min && ramp_q <= cfg_i.pwm_max)
    else $error("ramp level left the configured limits");

endmodule

// File: rtl/motor_setpoint_conditioner.sv
// ----------------------------------------------------------------------------
// motor_setpoint_conditioner
// Conditions one motor PWM setpoint word per control tick.
// ----------------------------------------------------------------------------
// Each input word is handled on its own, and the next word is taken only once
// the last one has gone through every step: the block takes the word, scales,
// selects and clamps it into the median window, searches for the median (it
// tests one window entry per cycle, so the filled depth of the window bounds the
// length of the search), then forms the weighted sum, divides by one hundred
// and applies the slew limiter. A finished result word waits in an output
// register, so the next input word is taken while the previous result is still
// unread; only when a second result is ready before the first is taken does the
// block hold in the ramp step. Configuration registers are written over the
// APB-style port and must only be changed while the block is idle.
// ----------------------------------------------------------------------------
module motor_setpoint_conditioner (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  // Input words.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [9:0] pot_sample, [20:10] manual_target, [23:21] zero
  input  logic [msc_pkg::IN_W-1:0]    s_axis_tdata,
  // [0] mode_auto
  input  logic [0:0]                  s_axis_tuser,

  // Result words.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [7:0] pot_scaled, [18:8] selected_value, [26:19] clamped_value,
  // [34:27] median_value, [42:35] average_value, [50:43] ramped_pwm,
  // [51] alert, [52] pwm_at_max, [55:53] zero
  output logic [msc_pkg::OUT_W-1:0]   m_axis_tdata,

  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import msc_pkg::*;

  cfg_t     cfg_q;
  cmd_t     cmd;
  stat_t    stat;
  result_t  result;
  reg_idx_e reg_idx;
  logic     cfg_wr;

  // The register index is the word address; the byte offset bits are ignored.
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration registers. Writes to indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwm_min        <= 8'd0;
      cfg_q.pwm_max        <= 8'(PWM_FULL);
      cfg_q.avg_weight_pct <= 7'd30;
      cfg_q.slew_step      <= 8'd5;
      cfg_q.alert_set_lvl  <= 8'd200;
      cfg_q.alert_clr_lvl  <= 8'd180;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PWM_MIN:    cfg_q.pwm_min        <= pwdata[7:0];
        REG_PWM_MAX:    cfg_q.pwm_max        <= pwdata[7:0];
        REG_AVG_WEIGHT: cfg_q.avg_weight_pct <= pwdata[6:0];
        REG_SLEW_STEP:  cfg_q.slew_step      <= pwdata[7:0];
        REG_ALERT_SET:  cfg_q.alert_set_lvl  <= pwdata[7:0];
        REG_ALERT_CLR:  cfg_q.alert_clr_lvl  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read-back of the register values.
  always_comb begin
    unique case (reg_idx)
      REG_PWM_MIN:    prdata = {24'b0, cfg_q.pwm_min};
      REG_PWM_MAX:    prdata = {24'b0, cfg_q.pwm_max};
      REG_AVG_WEIGHT: prdata = {25'b0, cfg_q.avg_weight_pct};
      REG_SLEW_STEP:  prdata = {24'b0, cfg_q.slew_step};
      REG_ALERT_SET:  prdata = {24'b0, cfg_q.alert_set_lvl};
      REG_ALERT_CLR:  prdata = {24'b0, cfg_q.alert_clr_lvl};
      default:        prdata = 32'b0;
    endcase
  end

  // The controller steps one word through the datapath and owns the
  // handshake on both streams.
  msc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  msc_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .mode_auto_i     (s_axis_tuser[0]),
    .pot_sample_i    (s_axis_tdata[9:0]),
    .manual_target_i (signed'(s_axis_tdata[20:10])),
    .result_o        (result)
  );

  assign m_axis_tdata = {(OUT_W - RESULT_W)'(0), result};

endmodule

// File: tb/setpoint_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// setpoint_checker
// Watches the input, result and register channels of the motor setpoint
// conditioner, predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
module setpoint_checker
  import msc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [IN_W-1:0]   in_data_i,
  input  logic [0:0]        in_user_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [OUT_W-1:0]  out_data_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [31:0]       pwdata_i,
  output int                fail_count_o,
  output int                pending_o
);

  // Own copy of the register file and of the filter state.
  cfg_t       cfg;
  logic [7:0] window [WINDOW_SIZE];
  int         slot;
  int         filled;
  int         avg_level;
  logic       avg_primed;
  int         ramp_level;
  logic       alert_held;
  result_t    conditioned_q [$];

  // Runs one setpoint word through the filter chain and updates the state.
  task automatic condition_word(input logic mode, input logic [9:0] pot,
                                input logic signed [10:0] manual,
                                output result_t res);
    int         lo, hi, sel, clamped, n, med, w, rl, step, j;
    logic [7:0] sorted [WINDOW_SIZE];
    logic [7:0] key;
    lo  = int'(cfg.pwm_min);
    hi  = int'(cfg.pwm_max);
    res = '0;
    if (mode) begin
      res.pot_scaled = 8'((int'(pot) * PWM_FULL) / POT_FULL);
      sel = int'(res.pot_scaled);
    end else begin
      sel = int'(manual);
    end
    // With crossed limits, the lower wins only for values below it.
    clamped = (sel < lo) ? lo : ((sel > hi) ? hi : sel);

    window[slot] = 8'(clamped);
    slot = (slot + 1) % WINDOW_SIZE;
    if (filled < WINDOW_SIZE) filled++;

    // Upper median of the entries written so far.
    n = filled;
    for (int i = 0; i < n; i++) sorted[i] = window[i];
    for (int i = 1; i < n; i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    med = int'(sorted[n/2]);

    if (!avg_primed) begin
      avg_level  = clamped;
      avg_primed = 1'b1;
    end else begin
      w = (int'(cfg.avg_weight_pct) > PCT_FULL) ? PCT_FULL : int'(cfg.avg_weight_pct);
      avg_level = (w * med + (PCT_FULL - w) * avg_level) / PCT_FULL;
    end

    rl   = ramp_level;
    step = int'(cfg.slew_step);
    if (avg_level > rl + step) rl = rl + step;
    else if (avg_level < rl - step) rl = rl - step;
    else rl = avg_level;
    ramp_level = (rl < lo) ? lo : ((rl > hi) ? hi : rl);

    if (alert_held) alert_held = (ramp_level >= int'(cfg.alert_clr_lvl));
    else alert_held = (ramp_level > int'(cfg.alert_set_lvl));

    res.selected_value = 11'(sel);
    res.clamped_value  = 8'(clamped);
    res.median_value   = 8'(med);
    res.average_value  = 8'(avg_level);
    res.ramped_pwm     = 8'(ramp_level);
    res.alert          = alert_held;
    res.pwm_at_max     = (ramp_level >= int'(cfg.pwm_max));
  endtask

  function automatic bit field_differs(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r, got_r, new_r;
    bit      bad;
    if (!rst_ni) begin
      cfg.pwm_min        <= 8'd0;
      cfg.pwm_max        <= 8'd255;
      cfg.avg_weight_pct <= 7'd30;
      cfg.slew_step      <= 8'd5;
      cfg.alert_set_lvl  <= 8'd200;
      cfg.alert_clr_lvl  <= 8'd180;
      slot         = 0;
      filled       = 0;
      avg_level    = 0;
      avg_primed   = 1'b0;
      ramp_level   = 0;
      alert_held   = 1'b0;
      conditioned_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got_r = result_t'(out_data_i[RESULT_W-1:0]);
        if (conditioned_q.size() == 0) begin
          $error("result word arrived with none expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = conditioned_q.pop_front();
          bad = 1'b0;
          bad |= field_differs("pot_scaled", exp_r.pot_scaled, got_r.pot_scaled);
          bad |= field_differs("selected_value", exp_r.selected_value,
                               got_r.selected_value);
          bad |= field_differs("clamped_value", exp_r.clamped_value, got_r.clamped_value);
          bad |= field_differs("median_value", exp_r.median_value, got_r.median_value);
          bad |= field_differs("average_value", exp_r.average_value, got_r.average_value);
          bad |= field_differs("ramped_pwm", exp_r.ramped_pwm, got_r.ramped_pwm);
          bad |= field_differs("alert", exp_r.alert, got_r.alert);
          bad |= field_differs("pwm_at_max", exp_r.pwm_at_max, got_r.pwm_at_max);
          if (bad) fail_count_o <= fail_count_o + 1;
        end
      end

      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[ADDR_W-1:2]))
          REG_PWM_MIN:    cfg.pwm_min        <= pwdata_i[7:0];
          REG_PWM_MAX:    cfg.pwm_max        <= pwdata_i[7:0];
          REG_AVG_WEIGHT: cfg.avg_weight_pct <= pwdata_i[6:0];
          REG_SLEW_STEP:  cfg.slew_step      <= pwdata_i[7:0];
          REG_ALERT_SET:  cfg.alert_set_lvl  <= pwdata_i[7:0];
          REG_ALERT_CLR:  cfg.alert_clr_lvl  <= pwdata_i[7:0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        condition_word(in_user_i[0], in_data_i[9:0], in_data_i[20:10], new_r);
        conditioned_q.push_back(new_r);
      end
      pending_o <= conditioned_q.size();
    end
  end

endmodule

// File: tb/tb_motor_setpoint_conditioner.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_motor_setpoint_conditioner
// Drives setpoint words and register writes into the conditioner and gives
// the verdict; a separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_motor_setpoint_conditioner;
  import msc_pkg::*;

  // Generous bound on the length of the whole run.
  localparam int CYCLE_LIMIT = 400000;
  // Cycles the block may still be busy once the last result word is taken.
  localparam int SETTLE_CYCLES = 16;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  // [9:0] pot_sample, [20:10] manual_target, [23:21] zero
  logic [IN_W-1:0]    s_axis_tdata  = '0;
  // [0] mode_auto
  logic [0:0]         s_axis_tuser  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // [7:0] pot_scaled, [18:8] selected_value, [26:19] clamped_value,
  // [34:27] median_value, [42:35] average_value, [50:43] ramped_pwm,
  // [51] alert, [52] pwm_at_max, [55:53] zero
  logic [OUT_W-1:0]   m_axis_tdata;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [ADDR_W-1:0]  paddr         = '0;
  logic [31:0]        pwdata        = '0;
  logic [31:0]        prdata;
  logic               pready;

  int mismatches;
  int outstanding;
  int cycle_cnt = 0;
  // When cleared, both sides run flat out with no idle cycles at all.
  bit idle_on   = 1'b1;
  int ready_left = 0;

  always #6 clk_i = ~clk_i;

  motor_setpoint_conditioner dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  setpoint_checker setpoint_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (mismatches),
    .pending_o    (outstanding)
  );

  // Watchdog. A hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side backpressure. Ready stretches and stall bursts alternate; the
  // end of a stall burst can give two back-to-back result words.
  always @(negedge clk_i) begin
    if (!idle_on) begin
      m_axis_tready <= 1'b1;
    end else if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else if (m_axis_tready) begin
      m_axis_tready <= 1'b0;
      ready_left    <= $urandom_range(0, 13);
    end else begin
      m_axis_tready <= 1'b1;
      ready_left    <= $urandom_range(0, 40);
    end
  end

  // One register write: a setup phase, then an access phase that completes
  // at the rising edge where pready is seen high.
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Holds off the sender until every predicted result word has been taken,
  // then lets the block settle. Registers may only change after this.
  // Valid is dropped first so the last word is not taken a second time.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_limits(input logic [7:0] lo, input logic [7:0] hi,
                             input logic [6:0] weight, input logic [7:0] step,
                             input logic [7:0] alert_hi, input logic [7:0] alert_lo);
    drain();
    write_reg(REG_PWM_MIN, 32'(lo));
    write_reg(REG_PWM_MAX, 32'(hi));
    write_reg(REG_AVG_WEIGHT, 32'(weight));
    write_reg(REG_SLEW_STEP, 32'(step));
    write_reg(REG_ALERT_SET, 32'(alert_hi));
    write_reg(REG_ALERT_CLR, 32'(alert_lo));
  endtask

  // Presents one setpoint word, sometimes after an idle burst, and returns
  // once it is accepted. Valid stays high into the next call so that words
  // can follow back to back.
  task automatic send_setpoint(input logic mode, input logic [9:0] pot,
                               input logic signed [10:0] manual);
    int gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {3'b000, manual, pot};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Mostly a typical byte from the given span, sometimes one of the rails.
  function automatic logic [7:0] pick_level(input int lo, input int hi);
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(lo, hi));
    endcase
  endfunction

  initial begin
    int           target, level, phases, words;
    logic [7:0]   lo, hi, step, alert_hi;
    logic [6:0]   weight;
    logic [9:0]   pot;
    logic signed [10:0] manual;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed words under the reset register values. The first word loads
    // the average directly; the rest cover the rails of the potentiometer
    // scaling and of the manual target, and wrap the median window.
    send_setpoint(1'b1, 10'd0, 11'sd0);
    send_setpoint(1'b1, 10'd1023, 11'sd0);
    send_setpoint(1'b1, 10'd1, -11'sd1);
    send_setpoint(1'b1, 10'd4, 11'sd0);
    send_setpoint(1'b1, 10'd5, 11'sd0);
    send_setpoint(1'b1, 10'd512, 11'sd1023);
    send_setpoint(1'b0, 10'd1023, -11'sd1024);
    send_setpoint(1'b0, 10'd0, 11'sd1023);
    send_setpoint(1'b0, 10'd0, -11'sd1);
    send_setpoint(1'b0, 10'd0, 11'sd255);
    send_setpoint(1'b0, 10'd0, 11'sd256);
    send_setpoint(1'b0, 10'd700, 11'sd128);

    // Crossed limits, a weight above one hundred and the widest ramp step.
    load_limits(8'd200, 8'd50, 7'd127, 8'd255, 8'd0, 8'd255);
    send_setpoint(1'b0, 10'd0, 11'sd100);
    send_setpoint(1'b0, 10'd0, 11'sd10);
    send_setpoint(1'b0, 10'd0, 11'sd250);
    send_setpoint(1'b1, 10'd1023, 11'sd0);
    send_setpoint(1'b0, 10'd0, -11'sd5);

    // A frozen ramp with zero weight, then full weight with a pinned range.
    load_limits(8'd0, 8'd255, 7'd0, 8'd0, 8'd255, 8'd0);
    send_setpoint(1'b0, 10'd0, 11'sd200);
    send_setpoint(1'b1, 10'd1023, 11'sd0);
    load_limits(8'd0, 8'd0, 7'd100, 8'd1, 8'd255, 8'd255);
    send_setpoint(1'b0, 10'd0, 11'sd77);
    send_setpoint(1'b1, 10'd300, 11'sd0);

    // Random phases, each under fresh register values. Most words follow a
    // drifting target so the average and the ramp travel far enough to cross
    // the alert band; the rest are raw noise over the whole input range.
    phases = 9;
    target = 128;
    for (int p = 0; p < phases; p++) begin
      lo       = pick_level(0, 80);
      hi       = pick_level(150, 255);
      weight   = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(101, 127))
                                             : 7'($urandom_range(0, 100));
      step     = pick_level(1, 40);
      alert_hi = pick_level(100, 250);
      // The final phase runs with no idling on either side.
      if (p == phases - 1) begin
        drain();
        idle_on = 1'b0;
      end
      load_limits(lo, hi, weight, step, alert_hi, pick_level(50, 240));
      words = 110;
      for (int k = 0; k < words; k++) begin
        if ($urandom_range(0, 9) < 7) begin
          if ($urandom_range(0, 19) == 0) target = $urandom_range(0, 255);
          else target = target + $urandom_range(0, 30) - 15;
          if (target < 0) target = 0;
          if (target > 255) target = 255;
          level = target + $urandom_range(0, 8) - 4;
          if (level < 0) level = 0;
          if (level > 255) level = 255;
          if ($urandom_range(0, 1) == 1) begin
            pot = 10'(level * 4 + $urandom_range(0, 3));
            send_setpoint(1'b1, pot, 11'($urandom));
          end else begin
            send_setpoint(1'b0, 10'($urandom), 11'(level));
          end
        end else begin
          pot    = 10'($urandom);
          manual = 11'($urandom);
          send_setpoint(1'($urandom), pot, manual);
        end
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    drain();

    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
